@@ hw/rtl/nfc_response_frame_parser_assert.svh @@
// assertion macros for the nfc response frame parser
// used only by the top level, no other dependencies
`ifndef NFC_RESPONSE_FRAME_PARSER_ASSERT_SVH
`define NFC_RESPONSE_FRAME_PARSER_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define NRFP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("nfc frame parser: same-cycle check failed");

// next-cycle implication, disabled while reset is low
`define NRFP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("nfc frame parser: next-cycle check failed");

`endif

@@ hw/rtl/nrfp_pkg.sv @@
// shared types and constants for the nfc response frame parser
// no dependencies; used by nfc_response_frame_parser
package nrfp_pkg;

    // frame parsing phases, one-hot
    typedef enum logic [10:0] {
        PH_POLL = 11'b000_0000_0001,
        PH_PRE0 = 11'b000_0000_0010,
        PH_PRE1 = 11'b000_0000_0100,
        PH_PRE2 = 11'b000_0000_1000,
        PH_LEN  = 11'b000_0001_0000,
        PH_LCS  = 11'b000_0010_0000,
        PH_TFI  = 11'b000_0100_0000,
        PH_CMD  = 11'b000_1000_0000,
        PH_DATA = 11'b001_0000_0000,
        PH_DCS  = 11'b010_0000_0000,
        PH_POST = 11'b100_0000_0000
    } t_phase;

    // end-of-response status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_TIMEOUT = 2'd1,
        ST_INVALID = 2'd2,
        ST_NOSPACE = 2'd3
    } t_status;

    // result kinds
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_REQUEST   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_POLL_LIM  = 2'd3;

    // widths and frame constants
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned POLL_W     = 17;
    localparam logic [POLL_W-1:0] POLL_MAX = 17'h1_FFFF;
    localparam logic [7:0] PREAMBLE_LO = 8'h00;
    localparam logic [7:0] PREAMBLE_HI = 8'hFF;
    localparam logic [7:0] MIN_LENGTH  = 8'd2;

    // reset values of the configuration registers
    localparam logic [7:0]            RST_REQUEST   = 8'd0;
    localparam logic [7:0]            RST_DIRECTION = 8'd213;
    localparam logic [7:0]            RST_CAPACITY  = 8'd255;
    localparam logic [CFG_DATA_W-1:0] RST_POLL_LIM  = 16'd1000;

endpackage

@@ hw/rtl/nfc_response_frame_parser.sv @@
// A result appears in the output register in the cycle after its byte is accepted.
// Throughput: one byte per cycle while o_rx_ready is high; the parser state machine
// updates at every accepted byte, the output register at every accepted byte that yields a
// result, and a stalled output still lets a new byte in if the output register is freed in the same cycle.
// Reset (i_rst_n low, synchronous): polling phase, counters cleared, output empty,
// configuration registers back to their defaults.
// nfc response frame parser top level
// depends on nrfp_pkg and nfc_response_frame_parser_assert.svh
`include "nfc_response_frame_parser_assert.svh"

module nfc_response_frame_parser (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [nrfp_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [nrfp_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // received byte channel
    input  logic                                i_rx_valid,
    output logic                                o_rx_ready,
    input  logic [7:0]                          i_rx_byte,
    // result channel
    output logic                                o_res_valid,
    input  logic                                i_res_ready,
    output logic                                o_out_kind,
    output logic [7:0]                          o_out_byte,
    output logic [1:0]                          o_out_status,
    output logic [7:0]                          o_out_length
);

    // configuration registers
    logic [7:0]                         r_request;
    logic [7:0]                         r_direction;
    logic [7:0]                         r_capacity;
    logic [nrfp_pkg::CFG_DATA_W-1:0]    r_poll_limit;

    // parser state
    nrfp_pkg::t_phase                   r_phase, n_phase;
    logic [nrfp_pkg::POLL_W-1:0]        r_poll_count, n_poll_count;
    logic [7:0]                         r_frame_length, n_frame_length;
    logic [7:0]                         r_remaining, n_remaining;
    logic [7:0]                         r_running_sum, n_running_sum;

    // output register
    logic                               r_res_valid;
    logic                               r_out_kind, n_out_kind;
    logic [7:0]                         r_out_byte, n_out_byte;
    nrfp_pkg::t_status                  r_out_status, n_out_status;
    logic [7:0]                         r_out_length, n_out_length;
    logic                               n_emit;

    // helpers
    logic                               rx_acc;
    logic [nrfp_pkg::POLL_W-1:0]        poll_inc;
    logic [7:0]                         payload_len;
    logic [7:0]                         rem_dec;
    logic [7:0]                         sum_add;
    logic [7:0]                         resp_code;

    // handshake: a byte enters whenever the output register is free or being drained
    assign o_rx_ready = !r_res_valid || i_res_ready;
    assign rx_acc     = i_rx_valid && o_rx_ready;

    assign poll_inc    = (r_poll_count == nrfp_pkg::POLL_MAX) ? r_poll_count
                                                              : r_poll_count + 1'b1;
    assign payload_len = r_frame_length - nrfp_pkg::MIN_LENGTH;
    assign rem_dec     = r_remaining - 8'd1;
    assign sum_add     = r_running_sum + i_rx_byte;
    assign resp_code   = r_request + 8'd1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_request    <= nrfp_pkg::RST_REQUEST;
            r_direction  <= nrfp_pkg::RST_DIRECTION;
            r_capacity   <= nrfp_pkg::RST_CAPACITY;
            r_poll_limit <= nrfp_pkg::RST_POLL_LIM;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                nrfp_pkg::REG_REQUEST:   r_request    <= i_cfg_data[7:0];
                nrfp_pkg::REG_DIRECTION: r_direction  <= i_cfg_data[7:0];
                nrfp_pkg::REG_CAPACITY:  r_capacity   <= i_cfg_data[7:0];
                nrfp_pkg::REG_POLL_LIM:  r_poll_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // next state and result for one accepted byte
    always_comb begin
        n_phase        = r_phase;
        n_poll_count   = r_poll_count;
        n_frame_length = r_frame_length;
        n_remaining    = r_remaining;
        n_running_sum  = r_running_sum;
        n_emit         = 1'b0;
        n_out_kind     = nrfp_pkg::KIND_END;
        n_out_byte     = 8'd0;
        n_out_status   = nrfp_pkg::ST_INVALID;
        n_out_length   = 8'd0;

        unique case (r_phase)
            nrfp_pkg::PH_POLL: begin
                if (i_rx_byte[0]) begin
                    n_poll_count = '0;
                    n_phase      = nrfp_pkg::PH_PRE0;
                end else if (r_poll_limit != '0 &&
                             poll_inc > {1'b0, r_poll_limit}) begin
                    n_poll_count = '0;
                    n_emit       = 1'b1;
                    n_out_status = nrfp_pkg::ST_TIMEOUT;
                end else begin
                    n_poll_count = poll_inc;
                end
            end
            nrfp_pkg::PH_PRE0: begin
                if (i_rx_byte != nrfp_pkg::PREAMBLE_LO) begin
                    n_emit  = 1'b1;
                    n_phase = nrfp_pkg::PH_POLL;
                end else begin
                    n_phase = nrfp_pkg::PH_PRE1;
                end
            end
            nrfp_pkg::PH_PRE1: begin
                if (i_rx_byte != nrfp_pkg::PREAMBLE_LO) begin
                    n_emit  = 1'b1;
                    n_phase = nrfp_pkg::PH_POLL;
                end else begin
                    n_phase = nrfp_pkg::PH_PRE2;
                end
            end
            nrfp_pkg::PH_PRE2: begin
                if (i_rx_byte != nrfp_pkg::PREAMBLE_HI) begin
                    n_emit  = 1'b1;
                    n_phase = nrfp_pkg::PH_POLL;
                end else begin
                    n_phase = nrfp_pkg::PH_LEN;
                end
            end
            nrfp_pkg::PH_LEN: begin
                n_frame_length = i_rx_byte;
                n_phase        = nrfp_pkg::PH_LCS;
            end
            nrfp_pkg::PH_LCS: begin
                // length check byte plus length must wrap to zero, and the
                // length has to cover direction and response code
                if ((r_frame_length + i_rx_byte) != 8'd0 ||
                    r_frame_length < nrfp_pkg::MIN_LENGTH) begin
                    n_emit  = 1'b1;
                    n_phase = nrfp_pkg::PH_POLL;
                end else begin
                    n_phase = nrfp_pkg::PH_TFI;
                end
            end
            nrfp_pkg::PH_TFI: begin
                if (i_rx_byte != r_direction) begin
                    n_emit  = 1'b1;
                    n_phase = nrfp_pkg::PH_POLL;
                end else begin
                    n_running_sum = i_rx_byte;
                    n_phase       = nrfp_pkg::PH_CMD;
                end
            end
            nrfp_pkg::PH_CMD: begin
                if (i_rx_byte != resp_code) begin
                    n_emit  = 1'b1;
                    n_phase = nrfp_pkg::PH_POLL;
                end else begin
                    n_running_sum = sum_add;
                    n_remaining   = payload_len;
                    if (payload_len > r_capacity) begin
                        n_emit       = 1'b1;
                        n_out_status = nrfp_pkg::ST_NOSPACE;
                        n_phase      = nrfp_pkg::PH_POLL;
                    end else if (payload_len == 8'd0) begin
                        n_phase = nrfp_pkg::PH_DCS;
                    end else begin
                        n_phase = nrfp_pkg::PH_DATA;
                    end
                end
            end
            nrfp_pkg::PH_DATA: begin
                // stream the payload byte out
                n_running_sum = sum_add;
                n_remaining   = rem_dec;
                if (rem_dec == 8'd0) begin
                    n_phase = nrfp_pkg::PH_DCS;
                end
                n_emit       = 1'b1;
                n_out_kind   = nrfp_pkg::KIND_DATA;
                n_out_byte   = i_rx_byte;
                n_out_status = nrfp_pkg::ST_OK;
            end
            nrfp_pkg::PH_DCS: begin
                if (sum_add != 8'd0) begin
                    n_emit  = 1'b1;
                    n_phase = nrfp_pkg::PH_POLL;
                end else begin
                    n_phase = nrfp_pkg::PH_POST;
                end
            end
            nrfp_pkg::PH_POST: begin
                // postamble value is not checked
                n_emit       = 1'b1;
                n_out_status = nrfp_pkg::ST_OK;
                n_out_length = payload_len;
                n_phase      = nrfp_pkg::PH_POLL;
            end
            default: begin
                n_phase      = nrfp_pkg::PH_POLL;
                n_poll_count = '0;
            end
        endcase
    end

    // parser state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= nrfp_pkg::PH_POLL;
            r_poll_count   <= '0;
            r_frame_length <= '0;
            r_remaining    <= '0;
            r_running_sum  <= '0;
        end else if (rx_acc) begin
            r_phase        <= n_phase;
            r_poll_count   <= n_poll_count;
            r_frame_length <= n_frame_length;
            r_remaining    <= n_remaining;
            r_running_sum  <= n_running_sum;
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (rx_acc && n_emit) begin
            r_res_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_res_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (rx_acc && n_emit) begin
            r_out_kind   <= n_out_kind;
            r_out_byte   <= n_out_byte;
            r_out_status <= n_out_status;
            r_out_length <= n_out_length;
        end
    end

    assign o_res_valid  = r_res_valid;
    assign o_out_kind   = r_out_kind;
    assign o_out_byte   = r_out_byte;
    assign o_out_status = r_out_status;
    assign o_out_length = r_out_length;

    // poll counter only runs while polling
    `NRFP_ASSERT_IMP(a_poll_idle, i_clk, i_rst_n,
        r_phase != nrfp_pkg::PH_POLL, r_poll_count == '0)
    // a payload result carries status OK and a zero length
    `NRFP_ASSERT_IMP(a_data_clean, i_clk, i_rst_n,
        r_res_valid && r_out_kind == nrfp_pkg::KIND_DATA,
        r_out_status == nrfp_pkg::ST_OK && r_out_length == 8'd0)
    // every accepted payload byte shows up in the output register
    `NRFP_ASSERT_NXT(a_data_out, i_clk, i_rst_n,
        rx_acc && r_phase == nrfp_pkg::PH_DATA,
        r_res_valid && r_out_kind == nrfp_pkg::KIND_DATA)

endmodule
